// ===== rtl/crfq_pkg.sv =====
// ----------------------------------------------------------------------------
// crfq_pkg
// Shared types, codes and helpers for the CAN receive frame queue.
// ----------------------------------------------------------------------------
`default_nettype none

package crfq_pkg;

   // default number of queued frames
   localparam int QUEUE_DEPTH_DEFAULT = 8;

   // field widths
   localparam int ID_W   = 29;
   localparam int LEN_W  = 4;
   localparam int WORD_W = 32;

   // operation codes
   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   // flag positions in the raw identifier word
   localparam int IDW_REMOTE_BIT   = 1;
   localparam int IDW_EXTENDED_BIT = 2;

   // control states of the top level
   typedef enum logic {
      ST_IDLE,
      ST_BUSY
   } state_type;

   // unpacked frame header, 35 bits
   typedef struct packed {
      logic [LEN_W-1:0] length;
      logic             remote;
      logic             extended;
      logic [ID_W-1:0]  identifier;
   } header_type;

   // one stored frame
   typedef struct packed {
      header_type        header;
      logic [WORD_W-1:0] data_high;
      logic [WORD_W-1:0] data_low;
   } frame_type;

   // captured request
   typedef struct packed {
      logic              operation;
      logic [WORD_W-1:0] identifier_word;
      logic [LEN_W-1:0]  length_code;
      logic [WORD_W-1:0] payload_low;
      logic [WORD_W-1:0] payload_high;
   } req_item_type;

   // response payload
   typedef struct packed {
      logic              frame_valid;
      logic              overflow;
      logic [ID_W-1:0]   frame_identifier;
      logic              is_extended;
      logic              is_remote;
      logic [LEN_W-1:0]  frame_length;
      logic [WORD_W-1:0] data_low_out;
      logic [WORD_W-1:0] data_high_out;
   } rsp_item_type;

   // control from the sequencer to the ring store
   typedef struct packed {
      logic      read;
      logic      write;
      logic      advance_read;
      frame_type write_frame;
   } ring_ctrl_type;

   // status from the ring store
   typedef struct packed {
      logic      full;
      logic      empty;
      frame_type read_frame;
   } ring_status_type;

   // unpack a raw receive mailbox item into a stored frame
   function automatic frame_type unpack_frame(input req_item_type item);
      frame_type f;
      f.header.extended = item.identifier_word[IDW_EXTENDED_BIT];
      f.header.remote   = item.identifier_word[IDW_REMOTE_BIT];
      f.header.length   = item.length_code;
      if (item.identifier_word[IDW_EXTENDED_BIT]) begin
         f.header.identifier = item.identifier_word[31:3];
      end else begin
         f.header.identifier = ID_W'(item.identifier_word[31:21]);
      end
      f.data_high = item.payload_high;
      f.data_low  = item.payload_low;
      return f;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/crfq_channels.sv =====
// ----------------------------------------------------------------------------
// crfq channels
// Valid/ready channel interfaces for requests and responses.
// ----------------------------------------------------------------------------
`default_nettype none

interface crfq_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [31:0] identifier_word;
   logic [3:0]  length_code;
   logic [31:0] payload_low;
   logic [31:0] payload_high;

   modport source (
      output valid, operation, identifier_word, length_code, payload_low, payload_high,
      input  ready
   );
   modport sink (
      input  valid, operation, identifier_word, length_code, payload_low, payload_high,
      output ready
   );
endinterface

interface crfq_rsp_if;
   logic        valid;
   logic        ready;
   logic        frame_valid;
   logic        overflow;
   logic [28:0] frame_identifier;
   logic        is_extended;
   logic        is_remote;
   logic [3:0]  frame_length;
   logic [31:0] data_low_out;
   logic [31:0] data_high_out;

   modport source (
      output valid, frame_valid, overflow, frame_identifier, is_extended, is_remote,
             frame_length, data_low_out, data_high_out,
      input  ready
   );
   modport sink (
      input  valid, frame_valid, overflow, frame_identifier, is_extended, is_remote,
             frame_length, data_low_out, data_high_out,
      output ready
   );
endinterface

`default_nettype wire

// ===== rtl/crfq_ring.sv =====
// ----------------------------------------------------------------------------
// crfq_ring
// Frame memory with write/read pointers and fill count; registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module crfq_ring #(
   parameter int QUEUE_DEPTH = crfq_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire                        clock,
   input  wire                        reset,
   input  crfq_pkg::ring_ctrl_type    ctrl,
   output crfq_pkg::ring_status_type  status
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   crfq_pkg::frame_type frame_mem [QUEUE_DEPTH];
   crfq_pkg::frame_type rd_data_ff;

   logic [PTR_W-1:0] wp_ff, wp_in;
   logic [PTR_W-1:0] rp_ff, rp_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // frame memory, written at the write pointer, read at the read pointer
   always_ff @(posedge clock) begin
      if (ctrl.write) begin
         frame_mem[wp_ff] <= ctrl.write_frame;
      end
      if (ctrl.read) begin
         rd_data_ff <= frame_mem[rp_ff];
      end
   end

   // pointer and count next values
   always_comb begin
      wp_in    = wp_ff;
      rp_in    = rp_ff;
      count_in = count_ff;
      if (ctrl.write) begin
         wp_in = (wp_ff == PTR_LAST) ? '0 : wp_ff + PTR_W'(1);
      end
      if (ctrl.advance_read) begin
         rp_in = (rp_ff == PTR_LAST) ? '0 : rp_ff + PTR_W'(1);
      end
      if (ctrl.write && !ctrl.advance_read) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!ctrl.write && ctrl.advance_read) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         rp_ff    <= '0;
         count_ff <= '0;
      end else begin
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
         count_ff <= count_in;
      end
   end

   // status toward the sequencer
   assign status.full       = (count_ff == CNT_FULL);
   assign status.empty      = (count_ff == '0);
   assign status.read_frame = rd_data_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("fill count beyond queue depth");

   a_no_write_full: assert property (@(posedge clock) disable iff (reset)
      ctrl.write |-> !status.full)
      else $error("write into a full queue");

   a_no_read_empty: assert property (@(posedge clock) disable iff (reset)
      ctrl.advance_read |-> !status.empty)
      else $error("read pointer advanced on an empty queue");

   a_ptr_count: assert property (@(posedge clock) disable iff (reset)
      (wp_ff != rp_ff) |-> (!status.empty && !status.full))
      else $error("pointers disagree with fill count");

endmodule

`default_nettype wire

// ===== rtl/can_receive_frame_queue_core.sv =====
// ----------------------------------------------------------------------------
// can_receive_frame_queue_core
// Ring queue of received CAN frames: push unpacks and stores, pop returns
// the oldest frame; a push to a full queue is dropped with overflow set.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake         | content
//  req_chan | in        | valid/ready       | operation, raw mailbox frame
//  rsp_chan | out       | valid/ready       | popped frame, status flags
//
//  each transaction is captured with the memory read issued, then it is
//  committed into the output register from the registered read data
//  a new request is taken while a finished response waits in the output
//  register; a stalled response holds the next item in the commit step
//  reset clears pointers, fill count and control; the frame memory is not
//  cleared, and an entry read before it is written is never returned, as
//  a pop on an empty queue gives a response with frame_valid low
`default_nettype none

module can_receive_frame_queue_core #(
   parameter int QUEUE_DEPTH = crfq_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire            clock,
   input  wire            reset,
   crfq_req_if.sink       req_chan,
   crfq_rsp_if.source     rsp_chan
);

   crfq_pkg::state_type       state_ff, state_in;
   crfq_pkg::req_item_type    item_ff;
   crfq_pkg::req_item_type    req_item;
   crfq_pkg::rsp_item_type    rsp_ff, rsp_in;
   crfq_pkg::ring_ctrl_type   ring_ctrl;
   crfq_pkg::ring_status_type ring_status;
   logic                      rsp_valid_ff;
   logic                      req_take;
   logic                      out_free;
   logic                      commit;
   logic                      is_push;

   // request payload gathered into one struct
   assign req_item.operation       = req_chan.operation;
   assign req_item.identifier_word = req_chan.identifier_word;
   assign req_item.length_code     = req_chan.length_code;
   assign req_item.payload_low     = req_chan.payload_low;
   assign req_item.payload_high    = req_chan.payload_high;

   assign req_take = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign is_push  = (item_ff.operation == crfq_pkg::OP_PUSH);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         crfq_pkg::ST_IDLE: begin
            if (req_take) begin
               state_in = crfq_pkg::ST_BUSY;
            end
         end
         crfq_pkg::ST_BUSY: begin
            if (out_free) begin
               state_in = crfq_pkg::ST_IDLE;
            end
         end
         default: state_in = crfq_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_chan.ready = 1'b0;
      commit         = 1'b0;
      case (state_ff)
         crfq_pkg::ST_IDLE: req_chan.ready = 1'b1;
         crfq_pkg::ST_BUSY: commit         = out_free;
         default: begin
            req_chan.ready = 1'b0;
            commit         = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= crfq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // captured transaction
   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= req_item;
      end
   end

   // ring store control: read issued on capture, write and advance on commit
   always_comb begin
      ring_ctrl.read         = req_take;
      ring_ctrl.write        = commit && is_push && !ring_status.full;
      ring_ctrl.advance_read = commit && !is_push && !ring_status.empty;
      ring_ctrl.write_frame  = crfq_pkg::unpack_frame(item_ff);
   end

   crfq_ring #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_ring (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ring_ctrl),
      .status (ring_status)
   );

   // response of the captured transaction
   always_comb begin
      rsp_in = '0;
      if (is_push) begin
         rsp_in.overflow = ring_status.full;
      end else if (!ring_status.empty) begin
         rsp_in.frame_valid      = 1'b1;
         rsp_in.frame_identifier = ring_status.read_frame.header.identifier;
         rsp_in.is_extended      = ring_status.read_frame.header.extended;
         rsp_in.is_remote        = ring_status.read_frame.header.remote;
         rsp_in.frame_length     = ring_status.read_frame.header.length;
         rsp_in.data_low_out     = ring_status.read_frame.data_low;
         rsp_in.data_high_out    = ring_status.read_frame.data_high;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.frame_valid      = rsp_ff.frame_valid;
   assign rsp_chan.overflow         = rsp_ff.overflow;
   assign rsp_chan.frame_identifier = rsp_ff.frame_identifier;
   assign rsp_chan.is_extended      = rsp_ff.is_extended;
   assign rsp_chan.is_remote        = rsp_ff.is_remote;
   assign rsp_chan.frame_length     = rsp_ff.frame_length;
   assign rsp_chan.data_low_out     = rsp_ff.data_low_out;
   assign rsp_chan.data_high_out    = rsp_ff.data_high_out;

endmodule

`default_nettype wire
